// ----- hdl/tcw_pkg.sv -----
// Package for the text console writer: geometry constants, field widths,
// command and state types, and the cell address helper. No dependencies.
package tcw_pkg;

   // Screen geometry
   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = COLS * ROWS;

   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int CELL_W = $clog2(CELLS);

   localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);
   localparam logic [CELL_W-1:0] COPY_N    = CELL_W'(CELLS - COLS);

   // Port field widths
   localparam int TYPE_FW = 2;
   localparam int CHAR_FW = 8;
   localparam int COL_FW  = 7;
   localparam int ROW_FW  = 5;
   localparam int ATTR_FW = 8;

   // Request codes
   localparam logic [TYPE_FW-1:0] REQ_PUT  = 2'd0;
   localparam logic [TYPE_FW-1:0] REQ_SET  = 2'd1;
   localparam logic [TYPE_FW-1:0] REQ_READ = 2'd2;

   localparam logic [CHAR_FW-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [ATTR_FW-1:0] ATTR_RESET   = 8'd15;

   typedef enum logic [2:0] {
      CMD_PUT_CHAR,
      CMD_NEWLINE,
      CMD_SET_CURSOR,
      CMD_READ_CELL,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [CHAR_FW-1:0]   char_code;
      logic [COL_W-1:0]     col;
      logic [ROW_W-1:0]     row;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_COPY,
      ST_ZERO,
      ST_DONE
   } back_state_type;

   function automatic logic [CELL_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      return CELL_W'(row) * CELL_W'(COLS) + CELL_W'(col);
   endfunction

endpackage

// ----- hdl/tcw_front.sv -----
// Front end of the text console writer: accepts request words, clamps the
// coordinates and classifies each one into a command. Uses tcw_pkg.
module tcw_front (
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tcw_pkg::TYPE_FW-1:0] req_type,
   input  logic [tcw_pkg::CHAR_FW-1:0] req_char_code,
   input  logic [tcw_pkg::COL_FW-1:0]  req_target_col,
   input  logic [tcw_pkg::ROW_FW-1:0]  req_target_row,
   input  tcw_pkg::q_status_type       q_status,
   input  tcw_pkg::back_status_type    back_status,
   output logic                        q_push,
   output tcw_pkg::cmd_type            q_push_cmd
);

   logic [tcw_pkg::COL_W-1:0] clamp_col;
   logic [tcw_pkg::ROW_W-1:0] clamp_row;

   // Hold off while the queue is full or the cell store is being cleared
   assign req_stall = q_status.full || back_status.clearing;
   assign q_push    = req_valid && !req_stall;

   assign clamp_col = (int'(req_target_col) > tcw_pkg::COLS - 1) ?
                      tcw_pkg::COL_W'(tcw_pkg::COLS - 1) :
                      tcw_pkg::COL_W'(req_target_col);
   assign clamp_row = (int'(req_target_row) > tcw_pkg::ROWS - 1) ?
                      tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) :
                      tcw_pkg::ROW_W'(req_target_row);

   always_comb begin
      q_push_cmd.char_code = req_char_code;
      q_push_cmd.col       = clamp_col;
      q_push_cmd.row       = clamp_row;
      unique case (req_type)
         tcw_pkg::REQ_PUT: begin
            q_push_cmd.kind = (req_char_code == tcw_pkg::NEWLINE_CODE) ?
                              tcw_pkg::CMD_NEWLINE : tcw_pkg::CMD_PUT_CHAR;
         end
         tcw_pkg::REQ_SET:  q_push_cmd.kind = tcw_pkg::CMD_SET_CURSOR;
         tcw_pkg::REQ_READ: q_push_cmd.kind = tcw_pkg::CMD_READ_CELL;
         default:           q_push_cmd.kind = tcw_pkg::CMD_NOP;
      endcase
   end

endmodule

// ----- hdl/tcw_queue.sv -----
// Two-entry command queue between front and back of the text console writer.
// Uses tcw_pkg for the command type.
module tcw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tcw_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output tcw_pkg::cmd_type      pop_cmd,
   output tcw_pkg::q_status_type status
);

   tcw_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hdl/tcw_back.sv -----
// Back end of the text console writer: cursor, cell store, scroll and clear
// sequencer, attribute register and the result output register. Uses tcw_pkg.
module tcw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tcw_pkg::ATTR_FW-1:0] csr_wr_data,
   input  tcw_pkg::cmd_type            cmd,
   input  tcw_pkg::q_status_type       q_status,
   output logic                        q_pop,
   output tcw_pkg::back_status_type    status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tcw_pkg::COL_FW-1:0]  rsp_cursor_col,
   output logic [tcw_pkg::ROW_FW-1:0]  rsp_cursor_row,
   output logic                        rsp_did_scroll,
   output logic [tcw_pkg::CHAR_FW-1:0] rsp_cell_char,
   output logic [tcw_pkg::ATTR_FW-1:0] rsp_cell_attr
);

   tcw_pkg::back_state_type state_ff, state_in;

   logic [15:0]                 mem_ff [tcw_pkg::CELLS];
   logic [15:0]                 rd_data_ff;
   logic                        mem_we, mem_re;
   logic [tcw_pkg::CELL_W-1:0]  mem_waddr, mem_raddr;
   logic [15:0]                 mem_wdata;

   logic [tcw_pkg::CELL_W-1:0]  idx_ff, idx_in;
   logic                        wr_pend_ff, wr_pend_in;
   logic [tcw_pkg::CELL_W-1:0]  wr_addr_ff, wr_addr_in;

   logic [tcw_pkg::COL_W-1:0]   cursor_col_ff, cursor_col_in;
   logic [tcw_pkg::ROW_W-1:0]   cursor_row_ff, cursor_row_in;
   logic [tcw_pkg::ATTR_FW-1:0] attr_ff, attr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::COL_FW-1:0]  rsp_col_ff, rsp_col_in;
   logic [tcw_pkg::ROW_FW-1:0]  rsp_row_ff, rsp_row_in;
   logic                        rsp_scroll_ff, rsp_scroll_in;
   logic [tcw_pkg::CHAR_FW-1:0] rsp_char_ff, rsp_char_in;
   logic [tcw_pkg::ATTR_FW-1:0] rsp_attr_ff, rsp_attr_in;
   logic                        load;

   logic                        out_free, take;
   logic                        at_last_col, at_last_row;
   logic                        put_wrap, put_scroll;
   logic [tcw_pkg::COL_W-1:0]   put_col;
   logic [tcw_pkg::ROW_W-1:0]   put_row;
   logic                        is_put;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign take        = !q_status.empty && out_free;
   assign is_put      = (cmd.kind == tcw_pkg::CMD_PUT_CHAR) ||
                        (cmd.kind == tcw_pkg::CMD_NEWLINE);
   assign at_last_col = (cursor_col_ff == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
   assign at_last_row = (cursor_row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
   assign put_wrap    = (cmd.kind == tcw_pkg::CMD_NEWLINE) || at_last_col;
   assign put_scroll  = put_wrap && at_last_row;
   assign put_col     = put_wrap ? '0 : cursor_col_ff + tcw_pkg::COL_W'(1);
   assign put_row     = !put_wrap   ? cursor_row_ff :
                        at_last_row ? tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1) :
                                      cursor_row_ff + tcw_pkg::ROW_W'(1);

   assign status.clearing = (state_ff == tcw_pkg::ST_CLEAR);
   assign attr_in         = csr_wr_en ? csr_wr_data : attr_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            if (idx_ff == tcw_pkg::CELL_LAST) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (take && cmd.kind == tcw_pkg::CMD_READ_CELL) begin
               state_in = tcw_pkg::ST_READ_WAIT;
            end else if (take && is_put && put_scroll) begin
               state_in = tcw_pkg::ST_COPY;
            end
         end
         tcw_pkg::ST_READ_WAIT: begin
            if (out_free) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_COPY: begin
            if (idx_ff == tcw_pkg::COPY_N) state_in = tcw_pkg::ST_ZERO;
         end
         tcw_pkg::ST_ZERO: begin
            if (idx_ff == tcw_pkg::CELL_LAST) state_in = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_DONE: begin
            if (out_free) state_in = tcw_pkg::ST_IDLE;
         end
         default: state_in = tcw_pkg::ST_CLEAR;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = idx_ff;
      idx_in        = idx_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = idx_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      load          = 1'b0;
      rsp_scroll_in = 1'b0;
      rsp_char_in   = '0;
      rsp_attr_in   = '0;
      unique case (state_ff)
         tcw_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            idx_in = idx_ff + tcw_pkg::CELL_W'(1);
         end
         tcw_pkg::ST_IDLE: begin
            if (take) begin
               q_pop = 1'b1;
               unique case (cmd.kind) inside
                  tcw_pkg::CMD_PUT_CHAR, tcw_pkg::CMD_NEWLINE: begin
                     if (cmd.kind == tcw_pkg::CMD_PUT_CHAR) begin
                        mem_we    = 1'b1;
                        mem_waddr = tcw_pkg::cell_addr(cursor_col_ff, cursor_row_ff);
                        mem_wdata = {attr_ff, cmd.char_code};
                     end
                     cursor_col_in = put_col;
                     cursor_row_in = put_row;
                     idx_in        = '0;
                     load          = !put_scroll;
                  end
                  tcw_pkg::CMD_SET_CURSOR: begin
                     cursor_col_in = cmd.col;
                     cursor_row_in = cmd.row;
                     load          = 1'b1;
                  end
                  tcw_pkg::CMD_READ_CELL: begin
                     mem_re    = 1'b1;
                     mem_raddr = tcw_pkg::cell_addr(cmd.col, cmd.row);
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         tcw_pkg::ST_READ_WAIT: begin
            load        = out_free;
            rsp_char_in = rd_data_ff[7:0];
            rsp_attr_in = rd_data_ff[15:8];
         end
         tcw_pkg::ST_COPY: begin
            // Read one row ahead, write the previous read back one row up
            mem_we    = wr_pend_ff;
            mem_waddr = wr_addr_ff;
            mem_wdata = rd_data_ff;
            if (idx_ff != tcw_pkg::COPY_N) begin
               mem_re     = 1'b1;
               mem_raddr  = idx_ff + tcw_pkg::CELL_W'(tcw_pkg::COLS);
               wr_pend_in = 1'b1;
               wr_addr_in = idx_ff;
               idx_in     = idx_ff + tcw_pkg::CELL_W'(1);
            end
         end
         tcw_pkg::ST_ZERO: begin
            mem_we = 1'b1;
            if (idx_ff != tcw_pkg::CELL_LAST) idx_in = idx_ff + tcw_pkg::CELL_W'(1);
         end
         tcw_pkg::ST_DONE: begin
            load          = out_free;
            rsp_scroll_in = 1'b1;
         end
         default: ;
      endcase
      rsp_col_in   = tcw_pkg::COL_FW'(cursor_col_in);
      rsp_row_in   = tcw_pkg::ROW_FW'(cursor_row_in);
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::ST_CLEAR;
         idx_ff        <= '0;
         wr_pend_ff    <= 1'b0;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         attr_ff       <= tcw_pkg::ATTR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         wr_pend_ff    <= wr_pend_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         attr_ff       <= attr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      if (load) begin
         rsp_col_ff    <= rsp_col_in;
         rsp_row_ff    <= rsp_row_in;
         rsp_scroll_ff <= rsp_scroll_in;
         rsp_char_ff   <= rsp_char_in;
         rsp_attr_ff   <= rsp_attr_in;
      end
   end

   // Cell store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_did_scroll = rsp_scroll_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;

`ifndef SYNTHESIS
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (int'(cursor_col_ff) < tcw_pkg::COLS) && (int'(cursor_row_ff) < tcw_pkg::ROWS))
      else $error("cursor left the screen");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == tcw_pkg::ST_IDLE) && !q_status.empty)
      else $error("command popped outside idle");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_waddr <= tcw_pkg::CELL_LAST))
      else $error("cell write out of range");

   a_copy_to_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_COPY && idx_ff == tcw_pkg::COPY_N)
      |=> (state_ff == tcw_pkg::ST_ZERO) && !wr_pend_ff)
      else $error("scroll copy did not hand over to row clear");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == tcw_pkg::ST_CLEAR) && !rsp_valid_ff)
      else $error("reset did not start the clearing pass");
`endif

endmodule

// ----- hdl/text_console_writer.sv -----
// Top level of the text console writer: front end, command queue and back end.
// Uses tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
// Usage:
//   Request words enter on req_* (valid/stall): put character, set cursor,
//   read cell. Every request produces exactly one result word on rsp_*,
//   carrying the cursor after the request, a scroll flag and, for a read,
//   the character and attribute of the cell. Coordinates are clamped.
//   csr_wr_en/csr_wr_data load the attribute byte used for written characters
//   (reset value 15); write it only while no request is in flight.
// Timing:
//   The front end classifies a request in the cycle it is accepted and drops
//   it into a two-entry queue; the back end takes it from there. Put, newline
//   and set cursor load the result register as they are taken, a read after the
//   registered cell store read. The back end takes one command per cycle when
//   idle and not stalled; a read holds it until loaded. A put past the last
//   cell or a newline on the bottom row scrolls: copy COLS*(ROWS-1) cells one
//   per cycle, then zero the last row; the queue fills and req_stall rises.
// Reset:
//   Synchronous reset starts a clearing pass over all COLS*ROWS cells, one
//   per cycle; req_stall stays high until it is done.
// Stall:
//   A stalled result holds in the output register; the back end stops taking
//   commands, and once the queue is full req_stall goes high.
module text_console_writer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [tcw_pkg::ATTR_FW-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tcw_pkg::TYPE_FW-1:0] req_type,
   input  logic [tcw_pkg::CHAR_FW-1:0] req_char_code,
   input  logic [tcw_pkg::COL_FW-1:0]  req_target_col,
   input  logic [tcw_pkg::ROW_FW-1:0]  req_target_row,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tcw_pkg::COL_FW-1:0]  rsp_cursor_col,
   output logic [tcw_pkg::ROW_FW-1:0]  rsp_cursor_row,
   output logic                        rsp_did_scroll,
   output logic [tcw_pkg::CHAR_FW-1:0] rsp_cell_char,
   output logic [tcw_pkg::ATTR_FW-1:0] rsp_cell_attr
);

   // Queue handshake between the two halves
   logic                     q_push;
   logic                     q_pop;
   tcw_pkg::cmd_type         q_push_cmd;
   tcw_pkg::cmd_type         q_pop_cmd;
   tcw_pkg::q_status_type    q_status;
   tcw_pkg::back_status_type back_status;

   // Front: accept, clamp, classify
   tcw_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .q_status       (q_status),
      .back_status    (back_status),
      .q_push         (q_push),
      .q_push_cmd     (q_push_cmd)
   );

   // Decouple the halves so each can stall on its own
   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_push_cmd),
      .pop      (q_pop),
      .pop_cmd  (q_pop_cmd),
      .status   (q_status)
   );

   // Back: execute against the cell store and drive results
   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .cmd            (q_pop_cmd),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .status         (back_status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_did_scroll (rsp_did_scroll),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr)
   );

endmodule

// ----- verif/text_console_checker.sv -----
// Checker for the text console writer: tracks the cell store, cursor and attribute,
// predicts one reply word per accepted request word and compares every reply.
// Depends on tcw_pkg for geometry, field widths and request codes.
module text_console_checker
   import tcw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ATTR_FW-1:0] csr_wr_data,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [TYPE_FW-1:0] req_type,
   input  logic [CHAR_FW-1:0] req_char_code,
   input  logic [COL_FW-1:0]  req_target_col,
   input  logic [ROW_FW-1:0]  req_target_row,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [COL_FW-1:0]  rsp_cursor_col,
   input  logic [ROW_FW-1:0]  rsp_cursor_row,
   input  logic               rsp_did_scroll,
   input  logic [CHAR_FW-1:0] rsp_cell_char,
   input  logic [ATTR_FW-1:0] rsp_cell_attr,
   output int                 fail_count,
   output int                 words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [COL_FW-1:0]  col;
      logic [ROW_FW-1:0]  row;
      logic               scrolled;
      logic [CHAR_FW-1:0] ch;
      logic [ATTR_FW-1:0] attr;
   } console_reply_t;

   logic [15:0]        screen_copy [CELLS];
   int unsigned        cursor_pos;
   logic [ATTR_FW-1:0] text_attr;
   console_reply_t     replies_due [$];

   initial begin
      fail_count = 0;
      words_due  = 0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   function automatic int unsigned clamped_cell(input logic [COL_FW-1:0] tcol,
                                                input logic [ROW_FW-1:0] trow);
      int unsigned c;
      int unsigned r;
      c = (tcol > COLS - 1) ? COLS - 1 : tcol;
      r = (trow > ROWS - 1) ? ROWS - 1 : trow;
      return r * COLS + c;
   endfunction

   function automatic console_reply_t apply_request(input logic [TYPE_FW-1:0] kind,
                                                    input logic [CHAR_FW-1:0] code,
                                                    input logic [COL_FW-1:0]  tcol,
                                                    input logic [ROW_FW-1:0]  trow);
      console_reply_t r;
      int unsigned    spot;
      r    = '0;
      spot = clamped_cell(tcol, trow);
      case (kind)
         REQ_PUT: begin
            if (code == NEWLINE_CODE) begin
               cursor_pos = (cursor_pos / COLS + 1) * COLS;
            end else begin
               if (cursor_pos < CELLS)
                  screen_copy[cursor_pos] = {text_attr, code};
               cursor_pos++;
            end
            // past the last cell: shift rows up, blank the bottom row
            if (cursor_pos >= CELLS) begin
               for (int i = 0; i < CELLS - COLS; i++)
                  screen_copy[i] = screen_copy[i + COLS];
               for (int i = CELLS - COLS; i < CELLS; i++)
                  screen_copy[i] = '0;
               cursor_pos -= COLS;
               r.scrolled = 1'b1;
            end
         end
         REQ_SET:  cursor_pos = spot;
         REQ_READ: {r.attr, r.ch} = screen_copy[spot];
         default: ;
      endcase
      r.col = COL_FW'(cursor_pos % COLS);
      r.row = ROW_FW'(cursor_pos / COLS);
      return r;
   endfunction

   always @(posedge clock) begin
      console_reply_t want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen_copy[i] = '0;
         cursor_pos = 0;
         text_attr  = ATTR_RESET;
         replies_due.delete();
      end else begin
         if (csr_wr_en)
            text_attr = csr_wr_data;
         // retire replies before queuing new ones: no reply can belong to a
         // request taken on the same edge
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               report_mismatch("reply word with nothing outstanding", 1, 0);
            end else begin
               want = replies_due.pop_front();
               if (rsp_cursor_col != want.col)
                  report_mismatch("cursor_col", rsp_cursor_col, want.col);
               if (rsp_cursor_row != want.row)
                  report_mismatch("cursor_row", rsp_cursor_row, want.row);
               if (rsp_did_scroll != want.scrolled)
                  report_mismatch("did_scroll", rsp_did_scroll, want.scrolled);
               if (rsp_cell_char != want.ch)
                  report_mismatch("cell_char", rsp_cell_char, want.ch);
               if (rsp_cell_attr != want.attr)
                  report_mismatch("cell_attr", rsp_cell_attr, want.attr);
            end
         end
         if (req_valid && !req_stall)
            replies_due.push_back(apply_request(req_type, req_char_code,
                                                req_target_col, req_target_row));
      end
      words_due = replies_due.size();
   end

endmodule

// ----- verif/tb_text_console_writer.sv -----
// Testbench top for the text console writer: clock, reset, request and reply
// traffic, attribute writes, watchdog and verdict.
// Depends on tcw_pkg, text_console_writer and text_console_checker.
module tb_text_console_writer;
   import tcw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Request code 3 is unused by the block; it must still answer with the cursor.
   localparam logic [TYPE_FW-1:0] REQ_UNUSED = 2'd3;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 6;
   localparam int MAX_GAP      = 13;
   localparam int LONG_HOLD    = 400;   // receiver hold-off, well past queue depth
   localparam int PHASE_WORDS  = 106;
   localparam int SETTLE       = 20;
   // Longest quiet stretch of a good run is the reset clear or a scroll
   // stacked on the long hold-off; allow a wide margin.
   localparam int QUIET_LIMIT  = 20000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [ATTR_FW-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   logic [TYPE_FW-1:0] req_type;
   logic [CHAR_FW-1:0] req_char_code;
   logic [COL_FW-1:0]  req_target_col;
   logic [ROW_FW-1:0]  req_target_row;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [COL_FW-1:0]  rsp_cursor_col;
   logic [ROW_FW-1:0]  rsp_cursor_row;
   logic               rsp_did_scroll;
   logic [CHAR_FW-1:0] rsp_cell_char;
   logic [ATTR_FW-1:0] rsp_cell_attr;

   int fail_count;
   int words_due;
   int quiet_cycles;
   bit fast_sender;     // set: offer words back to back
   bit rsp_hold_off;    // set: receiver takes one long hold-off at its next draw

   text_console_writer u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_did_scroll (rsp_did_scroll),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr)
   );

   text_console_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_did_scroll (rsp_did_scroll),
      .rsp_cell_char  (rsp_cell_char),
      .rsp_cell_attr  (rsp_cell_attr),
      .fail_count     (fail_count),
      .words_due      (words_due)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Watchdog: count cycles in which neither channel moves a word.
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request word; call at a falling edge, returns at the falling edge
   // after the word is taken, with valid still high. Lower valid only when a
   // gap is drawn, so valid never drops and rises in the same step.
   task automatic offer_request(input logic [TYPE_FW-1:0] kind,
                                input logic [CHAR_FW-1:0] code,
                                input logic [COL_FW-1:0]  tcol,
                                input logic [ROW_FW-1:0]  trow);
      int gap;
      gap = fast_sender ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_char_code  <= code;
      req_target_col <= tcol;
      req_target_row <= trow;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   // Drop valid and hold off until every outstanding reply has come back.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (words_due != 0) @(negedge clock);
   endtask

   // Single-cycle attribute write; only called with the block drained.
   task automatic load_attribute(input logic [ATTR_FW-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: mostly text runs (place cursor, write a few characters,
   // read back around the start), the rest raw words with every field random.
   task automatic stream_text(input int word_count);
      int               sent;
      int               run_len;
      int               reads;
      logic [COL_FW-1:0] c0;
      logic [ROW_FW-1:0] r0;
      logic [CHAR_FW-1:0] code;
      sent = 0;
      while (sent < word_count) begin
         fast_sender = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 8) begin
            // bias toward the bottom row and row ends so scrolls come often
            c0 = ($urandom_range(0, 3) == 0) ? COL_FW'($urandom_range(70, 79))
                                              : COL_FW'($urandom_range(0, 79));
            r0 = ($urandom_range(0, 2) == 0) ? ROW_FW'(ROWS - 1)
                                              : ROW_FW'($urandom_range(0, ROWS - 1));
            offer_request(REQ_SET, CHAR_FW'($urandom), c0, r0);
            run_len = $urandom_range(1, 8);
            for (int k = 0; k < run_len; k++) begin
               code = ($urandom_range(0, 6) == 0) ? NEWLINE_CODE : CHAR_FW'($urandom);
               offer_request(REQ_PUT, code, COL_FW'($urandom), ROW_FW'($urandom));
            end
            reads = $urandom_range(1, 3);
            for (int k = 0; k < reads; k++)
               offer_request(REQ_READ, CHAR_FW'($urandom), COL_FW'(c0 + k), r0);
            sent += 1 + run_len + reads;
         end else begin
            offer_request(TYPE_FW'($urandom), CHAR_FW'($urandom),
                          COL_FW'($urandom), ROW_FW'($urandom));
            sent++;
         end
      end
   endtask

   // Receiver: draw a stall length per reply word, with runs of no stall and
   // one long hold-off on request.
   initial begin
      bit fast_receiver;
      int hold;
      fast_receiver = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 15) == 0)
            fast_receiver = !fast_receiver;
         hold = fast_receiver ? 0 : $urandom_range(0, MAX_GAP);
         if (rsp_hold_off) begin
            hold         = LONG_HOLD;
            rsp_hold_off = 1'b0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      logic [ATTR_FW-1:0] phase_attr [5];
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_valid      = 1'b0;
      req_type       = '0;
      req_char_code  = '0;
      req_target_col = '0;
      req_target_row = '0;
      rsp_stall      = 1'b0;
      fast_sender    = 1'b0;
      rsp_hold_off   = 1'b0;
      phase_attr = '{8'hFF, 8'h00, ATTR_FW'($urandom), 8'h80, ATTR_FW'($urandom)};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, still on the reset attribute. The block clears its store
      // after reset; the first word simply waits out the stall.
      offer_request(REQ_READ, 8'h00, 7'd0, 5'd0);          // cleared cell
      offer_request(REQ_PUT, 8'h41, 7'd0, 5'd0);
      offer_request(REQ_PUT, 8'h00, 7'd0, 5'd0);           // lowest char code
      offer_request(REQ_PUT, 8'hFF, 7'h7F, 5'h1F);         // highest char code
      offer_request(REQ_PUT, NEWLINE_CODE, 7'd0, 5'd0);
      offer_request(REQ_READ, 8'h00, 7'd0, 5'd0);
      offer_request(REQ_READ, 8'hFF, 7'd2, 5'd0);
      // write into the last cell: cursor runs off the end and the screen scrolls
      offer_request(REQ_SET, 8'h00, 7'd79, 5'd24);
      offer_request(REQ_PUT, 8'h5A, 7'd0, 5'd0);
      offer_request(REQ_READ, 8'h00, 7'd79, 5'd23);        // moved up one row
      offer_request(REQ_READ, 8'h00, 7'd0, 5'd0);
      // newline on the bottom row scrolls and lands at column 0
      offer_request(REQ_SET, 8'h00, 7'd5, 5'd24);
      offer_request(REQ_PUT, NEWLINE_CODE, 7'd0, 5'd0);
      // out-of-range coordinates clamp to the last column and row
      offer_request(REQ_SET, 8'h00, 7'h7F, 5'h1F);
      offer_request(REQ_READ, 8'h00, 7'h7F, 5'h1F);
      offer_request(REQ_READ, 8'h00, 7'd80, 5'd25);
      // unused request code: no state change, cursor reported
      offer_request(REQ_UNUSED, 8'hFF, 7'h7F, 5'h1F);
      offer_request(REQ_SET, 8'h00, 7'd0, 5'd0);
      offer_request(REQ_READ, 8'h00, 7'd0, 5'd0);

      // Random phases, each on its own attribute. The sender drains before
      // every attribute write.
      for (int p = 0; p < 5; p++) begin
         drain_replies();
         load_attribute(phase_attr[p]);
         // second phase: hold the receiver off so the queue fills and the
         // block pushes back on its input
         if (p == 1)
            rsp_hold_off = 1'b1;
         stream_text(PHASE_WORDS);
      end

      drain_replies();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
